// File: rtl/khtb_pkg.sv
// Shared constants, command codes and character codes for the keyword hit table builder.
package khtb_pkg;

   // Table sizes in hash bits.
   localparam int SMALL_TABLE_BITS_DEF = 16;
   localparam int LARGE_TABLE_BITS_DEF = 20;

   // Widths of the result hash fields.
   localparam int HASH_SMALL_W = 16;
   localparam int HASH_LARGE_W = 20;

   // Each memory row holds 2**ROW_LOG table bits.
   localparam int ROW_LOG = 5;
   localparam int ROW_W   = 1 << ROW_LOG;

   // Request field widths.
   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Character codes.
   localparam logic [BYTE_W-1:0] CHAR_NUL        = 8'd0;
   localparam logic [BYTE_W-1:0] CHAR_APOSTROPHE = 8'd39;
   localparam logic [BYTE_W-1:0] CHAR_DIGIT_LO   = 8'd48;
   localparam logic [BYTE_W-1:0] CHAR_DIGIT_HI   = 8'd57;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_LO   = 8'd65;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_HI   = 8'd90;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_LO   = 8'd97;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_HI   = 8'd122;
   localparam logic [BYTE_W-1:0] CASE_OFFSET     = 8'd32;

   // Hash multiplier, processed one byte of the operand per step.
   localparam logic [31:0] HASH_MULT   = 32'h4F1BBCDC;
   localparam int          MUL_DIGIT_W = 8;
   localparam int          MUL_STEPS   = 32 / MUL_DIGIT_W;
   localparam int          MUL_STEP_W  = $clog2(MUL_STEPS);

endpackage

// File: rtl/khtb_if.sv
// Request and response channel interfaces of the keyword hit table builder.
interface khtb_req_if;
   import khtb_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] char_byte;
   logic              last_byte;

   modport source (output valid, output cmd, output char_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input cmd, input char_byte, input last_byte,
                   output ready);
endinterface

interface khtb_rsp_if;
   import khtb_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    word_valid;
   logic [HASH_SMALL_W-1:0] hash_small;
   logic [HASH_LARGE_W-1:0] hash_large;
   logic                    found_small;
   logic                    found_large;
   logic                    end_of_text;
   logic                    all_hit_small;
   logic                    all_hit_large;

   modport source (output valid, output word_valid, output hash_small, output hash_large,
                   output found_small, output found_large, output end_of_text,
                   output all_hit_small, output all_hit_large, input ready);
   modport sink   (input valid, input word_valid, input hash_small, input hash_large,
                   input found_small, input found_large, input end_of_text,
                   input all_hit_small, input all_hit_large, output ready);
endinterface

// File: rtl/khtb_mult.sv
// Iterative hash multiplier: one operand byte times the hash constant per cycle.
module khtb_mult (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] operand,
   output logic        done,
   output logic [31:0] product
);
   import khtb_pkg::*;

   logic                  busy_ff, busy_in;
   logic [MUL_STEP_W-1:0] step_ff, step_in;
   logic [31:0]           a_ff, a_in;
   logic [31:0]           m_ff, m_in;
   logic [31:0]           prod_ff, prod_in;

   // The last step finishes this cycle; the product register holds it next cycle.
   assign done    = busy_ff && (step_ff == MUL_STEP_W'(MUL_STEPS - 1));
   assign product = prod_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      a_in    = a_ff;
      m_in    = m_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         a_in    = operand;
         m_in    = HASH_MULT;
         prod_in = '0;
      end else if (busy_ff) begin
         prod_in = prod_ff + 32'(a_ff[MUL_DIGIT_W-1:0] * m_ff);
         a_in    = a_ff >> MUL_DIGIT_W;
         m_in    = m_ff << MUL_DIGIT_W;
         step_in = step_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      m_ff    <= m_in;
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/khtb_bitmap.sv
// Hit table memory: rows of table bits, one write and one registered read per cycle.
module khtb_bitmap #(
   parameter int TABLE_BITS = khtb_pkg::SMALL_TABLE_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       rd_en,
   input  logic [TABLE_BITS-khtb_pkg::ROW_LOG-1:0]    rd_addr,
   output logic [khtb_pkg::ROW_W-1:0]                 rd_data,
   input  logic                                       wr_en,
   input  logic [TABLE_BITS-khtb_pkg::ROW_LOG-1:0]    wr_addr,
   input  logic [khtb_pkg::ROW_W-1:0]                 wr_data
);
   import khtb_pkg::*;

   localparam int ROWS = 1 << (TABLE_BITS - ROW_LOG);

   logic [ROW_W-1:0] mem [ROWS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/keyword_hit_table_builder.sv
// Top level: keyword splitter, hash sequencer and the two hit tables.
// A byte that completes a keyword gives its response once the request is taken and has
// passed 4 multiplier steps, table read, probe and output load; a final byte with no
// keyword goes straight to output load; other bytes give no response. One request at a time.
// Clear sweeps 2**(max(SMALL_TABLE_BITS, LARGE_TABLE_BITS) - 5) rows (32768 by default),
// one table row per cycle. Reset is synchronous and runs the same clearing pass first.
module keyword_hit_table_builder #(
   parameter int SMALL_TABLE_BITS = khtb_pkg::SMALL_TABLE_BITS_DEF,
   parameter int LARGE_TABLE_BITS = khtb_pkg::LARGE_TABLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   khtb_req_if.sink   req_bus,
   khtb_rsp_if.source rsp_bus
);
   import khtb_pkg::*;

   // Row address widths of the two tables and of the clearing sweep.
   localparam int SA    = SMALL_TABLE_BITS - ROW_LOG;
   localparam int LA    = LARGE_TABLE_BITS - ROW_LOG;
   localparam int CLR_W = (SA > LA) ? SA : LA;

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_PROBE = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;

   // Keyword being built.
   logic [1:0]  wl_ff, wl_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  lane_ff, lane_in;
   logic        ended_ff, ended_in;

   // Query summary flags.
   logic q_all_s_ff, q_all_s_in;
   logic q_all_l_ff, q_all_l_in;
   logic q_saw_ff, q_saw_in;

   // Request being worked on.
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic             last_ff, last_in;
   logic             emit_ff, emit_in;
   logic             found_s_ff, found_s_in;
   logic             found_l_ff, found_l_in;

   // Response register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_word_ff, out_word_in;
   logic [HASH_SMALL_W-1:0] out_hs_ff, out_hs_in;
   logic [HASH_LARGE_W-1:0] out_hl_ff, out_hl_in;
   logic                    out_fs_ff, out_fs_in;
   logic                    out_fl_ff, out_fl_in;
   logic                    out_end_ff, out_end_in;
   logic                    out_ahs_ff, out_ahs_in;
   logic                    out_ahl_ff, out_ahl_in;

   // Request decode.
   logic              accept;
   logic [BYTE_W-1:0] b;
   logic              is_digit, is_upper, is_lower, alnum, ends_word;
   logic [BYTE_W-1:0] lc;
   logic [31:0]       acc_new;
   logic [1:0]        wl_new;
   logic              emit_now;

   // Multiplier and table ports.
   logic        mul_start, mul_done;
   logic [31:0] product;

   logic [SMALL_TABLE_BITS-1:0] hs;
   logic [LARGE_TABLE_BITS-1:0] hl;
   logic                        rd_en;
   logic [SA-1:0]               s_wr_addr;
   logic [LA-1:0]               l_wr_addr;
   logic                        s_wr_en, l_wr_en;
   logic [ROW_W-1:0]            s_rd_data, l_rd_data, s_wr_data, l_wr_data;
   logic                        s_hit, l_hit;
   logic                        out_free;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   // Character classes. Bytes 128 and above fall outside every range and act as breaks.
   assign b         = req_bus.char_byte;
   assign is_digit  = (b >= CHAR_DIGIT_LO) && (b <= CHAR_DIGIT_HI);
   assign is_upper  = (b >= CHAR_UPPER_LO) && (b <= CHAR_UPPER_HI);
   assign is_lower  = (b >= CHAR_LOWER_LO) && (b <= CHAR_LOWER_HI);
   assign alnum     = is_digit || is_upper || is_lower;
   assign ends_word = !alnum && (b != CHAR_APOSTROPHE);
   assign lc        = is_upper ? (b + CASE_OFFSET) : b;

   // The kept character goes into the byte lane of the little-endian accumulator.
   assign acc_new  = alnum ? (acc_ff ^ (32'(lc) << {lane_ff, 3'b000})) : acc_ff;
   assign wl_new   = (alnum && (wl_ff != 2'd2)) ? (wl_ff + 2'd1) : wl_ff;
   assign emit_now = !ended_ff && (wl_new == 2'd2) && (!alnum || req_bus.last_byte);

   assign mul_start = accept && (req_bus.cmd == CMD_INSERT || req_bus.cmd == CMD_QUERY)
                      && emit_now;

   khtb_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (acc_new),
      .done    (mul_done),
      .product (product)
   );

   // The hash is the top bits of the low 32 bits of the product.
   assign hs = product[31 -: SMALL_TABLE_BITS];
   assign hl = product[31 -: LARGE_TABLE_BITS];

   assign rd_en = (state_ff == ST_READ);
   assign s_hit = s_rd_data[hs[ROW_LOG-1:0]];
   assign l_hit = l_rd_data[hl[ROW_LOG-1:0]];

   // Write port: the clearing sweep zeroes rows; a probe under insert sets the word's bit.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         s_wr_en   = ({1'b0, clr_cnt_ff} < (CLR_W + 1)'(1 << SA));
         l_wr_en   = ({1'b0, clr_cnt_ff} < (CLR_W + 1)'(1 << LA));
         s_wr_addr = clr_cnt_ff[SA-1:0];
         l_wr_addr = clr_cnt_ff[LA-1:0];
         s_wr_data = '0;
         l_wr_data = '0;
      end else begin
         s_wr_en   = (state_ff == ST_PROBE) && (cmd_ff == CMD_INSERT);
         l_wr_en   = (state_ff == ST_PROBE) && (cmd_ff == CMD_INSERT);
         s_wr_addr = hs[SMALL_TABLE_BITS-1:ROW_LOG];
         l_wr_addr = hl[LARGE_TABLE_BITS-1:ROW_LOG];
         s_wr_data = s_rd_data | (ROW_W'(1) << hs[ROW_LOG-1:0]);
         l_wr_data = l_rd_data | (ROW_W'(1) << hl[ROW_LOG-1:0]);
      end
   end

   khtb_bitmap #(.TABLE_BITS(SMALL_TABLE_BITS)) u_small (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (hs[SMALL_TABLE_BITS-1:ROW_LOG]),
      .rd_data (s_rd_data),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data)
   );

   khtb_bitmap #(.TABLE_BITS(LARGE_TABLE_BITS)) u_large (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (hl[LARGE_TABLE_BITS-1:ROW_LOG]),
      .rd_data (l_rd_data),
      .wr_en   (l_wr_en),
      .wr_addr (l_wr_addr),
      .wr_data (l_wr_data)
   );

   // The response register may take a new response once the old one has been taken.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      wl_in        = wl_ff;
      acc_in       = acc_ff;
      lane_in      = lane_ff;
      ended_in     = ended_ff;
      q_all_s_in   = q_all_s_ff;
      q_all_l_in   = q_all_l_ff;
      q_saw_in     = q_saw_ff;
      cmd_in       = cmd_ff;
      last_in      = last_ff;
      emit_in      = emit_ff;
      found_s_in   = found_s_ff;
      found_l_in   = found_l_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_word_in  = out_word_ff;
      out_hs_in    = out_hs_ff;
      out_hl_in    = out_hl_ff;
      out_fs_in    = out_fs_ff;
      out_fl_in    = out_fl_ff;
      out_end_in   = out_end_ff;
      out_ahs_in   = out_ahs_ff;
      out_ahl_in   = out_ahl_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == {CLR_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_bus.cmd;
               last_in = req_bus.last_byte;
               if (req_bus.cmd == CMD_CLEAR) begin
                  clr_cnt_in = '0;
                  state_in   = ST_CLEAR;
               end else if (req_bus.cmd == CMD_INSERT || req_bus.cmd == CMD_QUERY) begin
                  emit_in = emit_now;
                  if (!ended_ff) begin
                     acc_in  = acc_new;
                     wl_in   = wl_new;
                     lane_in = alnum ? (lane_ff + 2'd1) : lane_ff;
                     if (ends_word) begin
                        acc_in  = '0;
                        wl_in   = '0;
                        lane_in = '0;
                     end
                     if (b == CHAR_NUL) begin
                        ended_in = 1'b1;
                     end
                  end
                  if (req_bus.last_byte) begin
                     acc_in   = '0;
                     wl_in    = '0;
                     lane_in  = '0;
                     ended_in = 1'b0;
                  end
                  if (emit_now) begin
                     state_in = ST_MUL;
                  end else if (req_bus.last_byte) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            found_s_in = s_hit;
            found_l_in = l_hit;
            if (cmd_ff == CMD_QUERY) begin
               q_all_s_in = q_all_s_ff && s_hit;
               q_all_l_in = q_all_l_ff && l_hit;
               q_saw_in   = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_word_in  = emit_ff;
               out_hs_in    = emit_ff ? HASH_SMALL_W'(hs) : '0;
               out_hl_in    = emit_ff ? HASH_LARGE_W'(hl) : '0;
               out_fs_in    = emit_ff && found_s_ff;
               out_fl_in    = emit_ff && found_l_ff;
               out_end_in   = last_ff;
               out_ahs_in   = last_ff && (cmd_ff == CMD_QUERY) && q_saw_ff && q_all_s_ff;
               out_ahl_in   = last_ff && (cmd_ff == CMD_QUERY) && q_saw_ff && q_all_l_ff;
               // The end of any text starts the next query summary afresh.
               if (last_ff) begin
                  q_all_s_in = 1'b1;
                  q_all_l_in = 1'b1;
                  q_saw_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         wl_ff        <= '0;
         acc_ff       <= '0;
         lane_ff      <= '0;
         ended_ff     <= 1'b0;
         q_all_s_ff   <= 1'b1;
         q_all_l_ff   <= 1'b1;
         q_saw_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wl_ff        <= wl_in;
         acc_ff       <= acc_in;
         lane_ff      <= lane_in;
         ended_ff     <= ended_in;
         q_all_s_ff   <= q_all_s_in;
         q_all_l_ff   <= q_all_l_in;
         q_saw_ff     <= q_saw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      last_ff     <= last_in;
      emit_ff     <= emit_in;
      found_s_ff  <= found_s_in;
      found_l_ff  <= found_l_in;
      out_word_ff <= out_word_in;
      out_hs_ff   <= out_hs_in;
      out_hl_ff   <= out_hl_in;
      out_fs_ff   <= out_fs_in;
      out_fl_ff   <= out_fl_in;
      out_end_ff  <= out_end_in;
      out_ahs_ff  <= out_ahs_in;
      out_ahl_ff  <= out_ahl_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.word_valid    = out_word_ff;
   assign rsp_bus.hash_small    = out_hs_ff;
   assign rsp_bus.hash_large    = out_hl_ff;
   assign rsp_bus.found_small   = out_fs_ff;
   assign rsp_bus.found_large   = out_fl_ff;
   assign rsp_bus.end_of_text   = out_end_ff;
   assign rsp_bus.all_hit_small = out_ahs_ff;
   assign rsp_bus.all_hit_large = out_ahl_ff;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the keyword hit table builder: name bytes in, hashes and hits out.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import khtb_pkg::*;

   // The block is built with its default table sizes.
   localparam int SMALL_BITS = SMALL_TABLE_BITS_DEF;
   localparam int LARGE_BITS = LARGE_TABLE_BITS_DEF;

   // The fourth command code has no meaning, and the block must ignore it.
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   // Character codes used when building text.
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'd45;

   // About this many counted requests go into each of the four idling phases.
   localparam int PHASE_REQUESTS = 363;

   // Run limit. Reset and every clear each sweep 32768 table rows, so the
   // limit is dominated by those sweeps and not by the byte traffic.
   localparam int RUN_LIMIT_NS = 3_000_000;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] char_byte;
      logic              last_byte;
   } text_byte_type;

   typedef struct packed {
      logic                    word_valid;
      logic [HASH_SMALL_W-1:0] hash_small;
      logic [HASH_LARGE_W-1:0] hash_large;
      logic                    found_small;
      logic                    found_large;
      logic                    end_of_text;
      logic                    all_hit_small;
      logic                    all_hit_large;
   } keyword_result_type;

   logic clock;
   logic reset;

   khtb_req_if req_bus ();
   khtb_rsp_if rsp_bus ();

   keyword_hit_table_builder u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Requests waiting to be driven, and the responses the predictor expects.
   text_byte_type      pending_requests[$];
   keyword_result_type expected_results[$];

   // Percent of cycles in which the sender holds back or the receiver stalls.
   int send_idle_pct;
   int stall_pct;

   // Set at each rising edge when the request on the bus was taken.
   bit req_taken;

   int mismatch_count;
   int request_count;

   // Predictor state: the keyword being assembled, the end-of-name marker,
   // the running query verdict, and the set bits of both hit tables.
   logic [1:0]  word_len;
   logic [31:0] word_xor;
   logic [1:0]  word_lane;
   bit          text_done;
   bit          query_all_small;
   bit          query_all_large;
   bit          query_saw_word;
   bit          small_marked[logic [31:0]];
   bit          large_marked[logic [31:0]];

   // Words that have been sent, so that queries can look up known names.
   string vocabulary[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Every input of the block is known from time zero. Reset is held from
   // time zero and released on a falling edge, once for the whole run.
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_INSERT;
      req_bus.char_byte = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic bit is_word_char(input logic [BYTE_W-1:0] ch);
      return (ch >= CHAR_DIGIT_LO && ch <= CHAR_DIGIT_HI) ||
             (ch >= CHAR_UPPER_LO && ch <= CHAR_UPPER_HI) ||
             (ch >= CHAR_LOWER_LO && ch <= CHAR_LOWER_HI);
   endfunction

   // Query-routing hash: multiply the folded word, keep the top bits of the
   // low 32 bits of the product.
   function automatic logic [31:0] routing_hash(input logic [31:0] folded, input int bits);
      logic [63:0] product;
      product = 64'(folded) * 64'(HASH_MULT);
      return product[31:0] >> (32 - bits);
   endfunction

   function automatic string describe(input keyword_result_type r);
      return $sformatf("word=%0b hs=%04h hl=%05h fs=%0b fl=%0b end=%0b ahs=%0b ahl=%0b",
                       r.word_valid, r.hash_small, r.hash_large, r.found_small,
                       r.found_large, r.end_of_text, r.all_hit_small, r.all_hit_large);
   endfunction

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic clear_word();
      word_len  = '0;
      word_xor  = '0;
      word_lane = '0;
   endtask

   task automatic clear_query();
      query_all_small = 1'b1;
      query_all_large = 1'b1;
      query_saw_word  = 1'b0;
   endtask

   // Works out what one taken request does to the tables and the keyword
   // state, and queues the response it should produce, if any.
   task automatic predict_keyword_hits(input text_byte_type req);
      keyword_result_type r;
      logic [BYTE_W-1:0]  folded_char;
      logic [31:0]        hs;
      logic [31:0]        hl;
      bit                 word_char;
      bit                 breaks_word;
      bit                 emit;
      bit                 fs;
      bit                 fl;
      r    = '0;
      emit = 1'b0;
      hs   = '0;
      hl   = '0;
      fs   = 1'b0;
      fl   = 1'b0;
      if (req.cmd == CMD_CLEAR) begin
         small_marked.delete();
         large_marked.delete();
         return;
      end
      if (req.cmd == CMD_RESERVED) begin
         return;
      end
      // Bytes after a NUL are skipped until the final byte of the text.
      if (!text_done) begin
         word_char   = is_word_char(req.char_byte);
         breaks_word = !word_char && req.char_byte != CHAR_APOSTROPHE;
         if (word_char) begin
            folded_char = req.char_byte;
            if (req.char_byte >= CHAR_UPPER_LO && req.char_byte <= CHAR_UPPER_HI) begin
               folded_char = req.char_byte + CASE_OFFSET;
            end
            word_xor  = word_xor ^ (32'(folded_char) << (8 * word_lane));
            word_lane = word_lane + 2'd1;
            if (word_len < 2'd2) begin
               word_len = word_len + 2'd1;
            end
         end
         // An apostrophe reports the word so far but keeps building it.
         emit = word_len >= 2'd2 && (!word_char || req.last_byte);
         if (emit) begin
            hs = routing_hash(word_xor, SMALL_BITS);
            hl = routing_hash(word_xor, LARGE_BITS);
            fs = small_marked.exists(hs);
            fl = large_marked.exists(hl);
            if (req.cmd == CMD_INSERT) begin
               small_marked[hs] = 1'b1;
               large_marked[hl] = 1'b1;
            end else begin
               query_all_small = query_all_small && fs;
               query_all_large = query_all_large && fl;
               query_saw_word  = 1'b1;
            end
         end
         if (breaks_word || req.last_byte) begin
            clear_word();
         end
         if (req.char_byte == CHAR_NUL) begin
            text_done = 1'b1;
         end
      end
      if (!emit && !req.last_byte) begin
         return;
      end
      if (req.last_byte) begin
         if (req.cmd == CMD_QUERY) begin
            r.all_hit_small = query_saw_word && query_all_small;
            r.all_hit_large = query_saw_word && query_all_large;
         end
         clear_query();
         clear_word();
         text_done = 1'b0;
      end
      r.word_valid  = emit;
      r.hash_small  = hs[HASH_SMALL_W-1:0];
      r.hash_large  = hl[HASH_LARGE_W-1:0];
      r.found_small = fs;
      r.found_large = fl;
      r.end_of_text = req.last_byte;
      expected_results.insert(expected_results.size(), r);
   endtask

   // Driver: a new request goes out on a falling edge when the bus is free or
   // the previous request was just taken. Valid stays up until the handshake.
   always @(negedge clock) begin
      text_byte_type next_req;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = pending_requests.pop_front();
            req_bus.cmd       <= next_req.cmd;
            req_bus.char_byte <= next_req.char_byte;
            req_bus.last_byte <= next_req.last_byte;
            req_bus.valid     <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: ready is redrawn every cycle from the current stall rate.
   always @(negedge clock) begin
      rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
   end

   // Monitor: a response is checked before the request of the same edge is
   // predicted. The block serves one request at a time, so a response that
   // leaves on the edge where a new request enters belongs to an older one.
   always @(posedge clock) begin
      keyword_result_type seen;
      keyword_result_type want;
      text_byte_type      taken_req;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = '{word_valid:    rsp_bus.word_valid,
                     hash_small:    rsp_bus.hash_small,
                     hash_large:    rsp_bus.hash_large,
                     found_small:   rsp_bus.found_small,
                     found_large:   rsp_bus.found_large,
                     end_of_text:   rsp_bus.end_of_text,
                     all_hit_small: rsp_bus.all_hit_small,
                     all_hit_large: rsp_bus.all_hit_large};
            if (expected_results.size() == 0) begin
               flag_error({"response with nothing expected: ", describe(seen)});
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  flag_error({"expected ", describe(want), " got ", describe(seen)});
               end
            end
         end
         req_taken = req_bus.valid && req_bus.ready;
         if (req_taken) begin
            taken_req = '{cmd: req_bus.cmd, char_byte: req_bus.char_byte,
                          last_byte: req_bus.last_byte};
            predict_keyword_hits(taken_req);
         end
      end
   end

   task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] ch,
                               input logic last);
      text_byte_type item;
      item = '{cmd: cmd, char_byte: ch, last_byte: last};
      pending_requests.insert(pending_requests.size(), item);
      if (cmd != CMD_RESERVED) begin
         request_count++;
      end
   endtask

   // A byte that splits words: mostly spaces, sometimes punctuation, an
   // apostrophe or a byte from the upper half of the code range.
   function automatic logic [BYTE_W-1:0] pick_break();
      logic [BYTE_W-1:0] ch;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: ch = CHAR_SPACE;
         4:          ch = CHAR_APOSTROPHE;
         5:          ch = CHAR_DASH;
         6:          ch = 8'($urandom_range(128, 255));
         default: begin
            ch = 8'($urandom_range(1, 127));
            while (is_word_char(ch)) ch = 8'($urandom_range(1, 127));
         end
      endcase
      return ch;
   endfunction

   function automatic string fresh_word();
      string w;
      int    n;
      w = "";
      n = $urandom_range(1, 7);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) begin
            w = {w, string'(8'($urandom_range(CHAR_DIGIT_LO, CHAR_DIGIT_HI)))};
         end else begin
            w = {w, string'(8'($urandom_range(CHAR_LOWER_LO, CHAR_LOWER_HI)))};
         end
      end
      return w;
   endfunction

   // One well-formed text: a few words with breaks between them, sometimes a
   // trailing break, sometimes a NUL followed by bytes that must be skipped.
   // Queries mostly reuse known words so that table hits are common.
   task automatic queue_text(input logic [CMD_W-1:0] cmd, input bit mixed);
      logic [BYTE_W-1:0] text[$];
      logic [BYTE_W-1:0] ch;
      logic [CMD_W-1:0]  byte_cmd;
      string             w;
      int                nwords;
      int                reuse_pct;
      nwords    = $urandom_range(1, 4);
      reuse_pct = (cmd == CMD_QUERY) ? 85 : 40;
      for (int k = 0; k < nwords; k++) begin
         if (k > 0) begin
            repeat ($urandom_range(1, 2)) text.insert(text.size(), pick_break());
         end
         if (vocabulary.size() != 0 && $urandom_range(0, 99) < reuse_pct) begin
            w = vocabulary[$urandom_range(0, vocabulary.size() - 1)];
         end else begin
            w = fresh_word();
            if (vocabulary.size() < 48) begin
               vocabulary.insert(vocabulary.size(), w);
            end else begin
               vocabulary[$urandom_range(0, 47)] = w;
            end
         end
         for (int i = 0; i < w.len(); i++) begin
            ch = w[i];
            if (ch >= CHAR_LOWER_LO && ch <= CHAR_LOWER_HI && $urandom_range(0, 2) == 0) begin
               ch = ch - CASE_OFFSET;
            end
            text.insert(text.size(), ch);
         end
      end
      case ($urandom_range(0, 9))
         0, 1: text.insert(text.size(), pick_break());
         2: begin
            text.insert(text.size(), CHAR_NUL);
            repeat ($urandom_range(0, 3)) text.insert(text.size(), 8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      for (int i = 0; i < text.size(); i++) begin
         byte_cmd = mixed ? CMD_W'($urandom_range(CMD_INSERT, CMD_QUERY)) : cmd;
         push_request(byte_cmd, text[i], i == text.size() - 1);
      end
   endtask

   // Stimulus: a short directed part, then four random phases with
   // different idling, each drained before the next begins.
   initial begin
      int stop_at;
      int clear_at;
      int pick;
      bit cleared;
      send_idle_pct   = 0;
      stall_pct       = 0;
      mismatch_count  = 0;
      request_count   = 0;
      req_taken       = 1'b0;
      text_done       = 1'b0;
      clear_word();
      clear_query();

      // Apostrophe inside a word reports "zy", then the final byte "zy9".
      push_request(CMD_INSERT, "Z", 1'b0);
      push_request(CMD_INSERT, "y", 1'b0);
      push_request(CMD_INSERT, CHAR_APOSTROPHE, 1'b0);
      push_request(CMD_INSERT, "9", 1'b1);
      // A one-letter word is dropped; an apostrophe on the final byte reports once.
      push_request(CMD_INSERT, "q", 1'b0);
      push_request(CMD_INSERT, 8'hFF, 1'b0);
      push_request(CMD_INSERT, "0", 1'b0);
      push_request(CMD_INSERT, "Z", 1'b0);
      push_request(CMD_INSERT, CHAR_APOSTROPHE, 1'b1);
      // A NUL ends the name; the bytes after it are skipped.
      push_request(CMD_INSERT, "m", 1'b0);
      push_request(CMD_INSERT, "n", 1'b0);
      push_request(CMD_INSERT, CHAR_NUL, 1'b0);
      push_request(CMD_INSERT, "a", 1'b0);
      push_request(CMD_INSERT, "b", 1'b1);
      // Query where every word is known.
      push_request(CMD_QUERY, "Z", 1'b0);
      push_request(CMD_QUERY, "Y", 1'b0);
      push_request(CMD_QUERY, CHAR_SPACE, 1'b0);
      push_request(CMD_QUERY, "z", 1'b0);
      push_request(CMD_QUERY, "y", 1'b0);
      push_request(CMD_QUERY, "9", 1'b1);
      // Query with an unknown word.
      push_request(CMD_QUERY, "z", 1'b0);
      push_request(CMD_QUERY, "z", 1'b1);
      // The unused command is ignored; after a clear a known word misses.
      push_request(CMD_RESERVED, 8'hA5, 1'b1);
      push_request(CMD_CLEAR, 8'h00, 1'b0);
      push_request(CMD_QUERY, "z", 1'b0);
      push_request(CMD_QUERY, "y", 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         while (pending_requests.size() != 0 || req_bus.valid) @(posedge clock);
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 86; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 86; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         stop_at  = request_count + PHASE_REQUESTS;
         clear_at = request_count + $urandom_range(40, PHASE_REQUESTS - 40);
         cleared  = 1'b0;
         while (request_count < stop_at) begin
            if (!cleared && request_count >= clear_at) begin
               push_request(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               cleared = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
               queue_text(CMD_INSERT, 1'b0);
            end else if (pick < 82) begin
               queue_text(CMD_QUERY, 1'b0);
            end else if (pick < 90) begin
               queue_text(CMD_QUERY, 1'b1);
            end else if (pick < 97) begin
               // Noise: raw bytes under either command, the text may run on.
               repeat ($urandom_range(2, 6)) begin
                  push_request(CMD_W'($urandom_range(CMD_INSERT, CMD_QUERY)),
                               8'($urandom_range(0, 255)), 1'($urandom_range(0, 9) == 0));
               end
            end else begin
               push_request(CMD_RESERVED, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            end
         end
      end

      // Close any text left open by noise so its final response is checked.
      push_request(CMD_INSERT, CHAR_SPACE, 1'b1);
      while (pending_requests.size() != 0 || req_bus.valid) @(posedge clock);

      // Wait for the responses still owed, then a little longer than the
      // slowest keyword takes, so that a stray extra response is caught.
      while (expected_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (expected_results.size() != 0) begin
         flag_error($sformatf("%0d responses never arrived", expected_results.size()));
      end
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/khtb_pkg.sv
rtl/khtb_if.sv
rtl/khtb_mult.sv
rtl/khtb_bitmap.sv
rtl/keyword_hit_table_builder.sv
sim/testbench.sv
